// ===== design/utf8d_pkg.sv =====
`timescale 1ns / 1ps
// Types and constants shared by the UTF-8 decoder, its channel interfaces and its checker.
// No dependencies.
package utf8d_pkg;

  typedef logic [7:0]  text_byte_t;
  typedef logic [20:0] code_point_t;
  typedef logic [2:0]  seq_len_t;
  typedef logic [1:0]  remain_t;

  // Lead byte classes: a byte matches when (byte & MASK) == CODE
  localparam text_byte_t ASCII_MASK = 8'h80;
  localparam text_byte_t ASCII_CODE = 8'h00;
  localparam text_byte_t CONT_MASK  = 8'hC0;
  localparam text_byte_t CONT_CODE  = 8'h80;
  localparam text_byte_t LEAD2_MASK = 8'hE0;
  localparam text_byte_t LEAD2_CODE = 8'hC0;
  localparam text_byte_t LEAD3_MASK = 8'hF0;
  localparam text_byte_t LEAD3_CODE = 8'hE0;
  localparam text_byte_t LEAD4_MASK = 8'hF8;
  localparam text_byte_t LEAD4_CODE = 8'hF0;

  // Payload bits kept from each byte kind
  localparam text_byte_t LEAD2_BITS = 8'h1F;
  localparam text_byte_t LEAD3_BITS = 8'h0F;
  localparam text_byte_t LEAD4_BITS = 8'h07;
  localparam text_byte_t CONT_BITS  = 8'h3F;

  localparam text_byte_t TERMINATOR = 8'h00;

  localparam seq_len_t LEN1 = 3'd1;
  localparam seq_len_t LEN2 = 3'd2;
  localparam seq_len_t LEN3 = 3'd3;
  localparam seq_len_t LEN4 = 3'd4;

  // Largest code point each length can carry
  localparam code_point_t MAX_LEN1 = 21'h00007F;
  localparam code_point_t MAX_LEN2 = 21'h0007FF;
  localparam code_point_t MAX_LEN3 = 21'h00FFFF;

endpackage

// ===== design/utf8d_byte_if.sv =====
`timescale 1ns / 1ps
// Byte channel into the UTF-8 decoder: valid/ready handshake with one text byte.
// Depends on utf8d_pkg.
interface utf8d_byte_if import utf8d_pkg::*; ();
  logic       valid;
  logic       ready;
  text_byte_t text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

// ===== design/utf8d_cp_if.sv =====
`timescale 1ns / 1ps
// Code point channel out of the UTF-8 decoder: valid/ready handshake with value and length.
// Depends on utf8d_pkg.
interface utf8d_cp_if import utf8d_pkg::*; ();
  logic        valid;
  logic        ready;
  code_point_t code_point;
  seq_len_t    sequence_length;

  modport source (output valid, output code_point, output sequence_length, input ready);
  modport sink   (input valid, input code_point, input sequence_length, output ready);
endinterface

// ===== design/utf8_codepoint_decoder.sv =====
`timescale 1ns / 1ps
// Lenient UTF-8 decoder: one byte word in per cycle, one code point word out per sequence.
// A result is valid in the cycle after the word holding its last byte is accepted.
// Throughput: one byte per cycle; the output register reloads in the cycle the sink takes
// its word, and the input stalls only when that register holds a result the sink has not taken.
// Reset (synchronous, rst high) returns the decoder to idle and empties the output register.
// Depends on utf8d_pkg, utf8d_byte_if and utf8d_cp_if.
module utf8_codepoint_decoder import utf8d_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  utf8d_byte_if.sink    text,
  utf8d_cp_if.source    decoded
);

  // Sequence state
  remain_t     remain, remain_next;
  code_point_t partial, partial_next;
  seq_len_t    seq_size, seq_size_next;

  // Output register
  logic        out_valid;
  code_point_t out_cp;
  seq_len_t    out_len;

  logic        accept;
  logic        emit;
  code_point_t emit_cp;
  seq_len_t    emit_len;
  text_byte_t  b;
  code_point_t shifted;

  assign text.ready = !out_valid || decoded.ready;
  assign accept     = text.valid && text.ready;
  assign b          = text.text_byte;
  assign shifted    = {partial[14:0], b[5:0]};

  always_comb begin
    remain_next   = remain;
    partial_next  = partial;
    seq_size_next = seq_size;
    emit          = 1'b0;
    emit_cp       = shifted;
    emit_len      = seq_size;
    priority if (b == TERMINATOR) begin
      // drop any unfinished sequence
      remain_next = '0;
    end else if (remain != '0) begin
      partial_next = shifted;
      remain_next  = remain - 2'd1;
      if (remain == 2'd1) begin
        emit = 1'b1;
      end
    end else if ((b & ASCII_MASK) == ASCII_CODE) begin
      emit     = 1'b1;
      emit_cp  = {13'd0, b};
      emit_len = LEN1;
    end else if ((b & CONT_MASK) == CONT_CODE) begin
      // skip stray continuation
    end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
      partial_next  = {13'd0, b & LEAD2_BITS};
      seq_size_next = LEN2;
      remain_next   = 2'd1;
    end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
      partial_next  = {13'd0, b & LEAD3_BITS};
      seq_size_next = LEN3;
      remain_next   = 2'd2;
    end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
      partial_next  = {13'd0, b & LEAD4_BITS};
      seq_size_next = LEN4;
      remain_next   = 2'd3;
    end else begin
      // skip invalid lead byte
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remain <= '0;
    end else if (accept) begin
      remain <= remain_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      partial  <= partial_next;
      seq_size <= seq_size_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && emit) begin
      out_valid <= 1'b1;
    end else if (decoded.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_cp  <= emit_cp;
      out_len <= emit_len;
    end
  end

  assign decoded.valid           = out_valid;
  assign decoded.code_point      = out_cp;
  assign decoded.sequence_length = out_len;

endmodule

// ===== design/utf8d_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the UTF-8 decoder, bound to every instance of the top level.
// Depends on utf8d_pkg and utf8_codepoint_decoder.
module utf8d_checker import utf8d_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input text_byte_t  in_byte,
  input logic        out_valid,
  input logic        out_ready,
  input code_point_t out_cp,
  input seq_len_t    out_len
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_cp) && $stable(out_len))
    else $error("result word changed while stalled");

  // input never waits on an empty output register
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_len == LEN1) || (out_len == LEN2) || (out_len == LEN3)
                  || (out_len == LEN4))
    else $error("sequence length out of range");

  a_cp_fits_len: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_len != LEN1) || (out_cp <= MAX_LEN1))
               && ((out_len != LEN2) || (out_cp <= MAX_LEN2))
               && ((out_len != LEN3) || (out_cp <= MAX_LEN3)))
    else $error("code point too wide for its length");

  // a terminator never produces a result
  a_term_no_result: assert property (@(posedge clk) disable iff (rst)
    in_acc && in_byte == TERMINATOR && (!out_valid || out_ready) |=> !out_valid)
    else $error("result after terminator");

endmodule

bind utf8_codepoint_decoder utf8d_checker u_utf8d_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (text.valid),
  .in_ready  (text.ready),
  .in_byte   (text.text_byte),
  .out_valid (decoded.valid),
  .out_ready (decoded.ready),
  .out_cp    (decoded.code_point),
  .out_len   (decoded.sequence_length)
);
